// ----- hdl/bsr_pkg.sv -----
// shared types, constants and the sinc coefficient rom for the block resampler
package bsr_pkg;

  localparam int unsigned BLOCK_LEN_DEF = 20;
  localparam int unsigned BLOCK_LEN_MAX = 21;
  localparam int unsigned UP_FACTOR     = 3;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned COEF_W        = 17;
  localparam int unsigned COEF_IW       = 6;
  localparam int unsigned IDX_W         = $clog2(BLOCK_LEN_MAX);
  localparam int unsigned DOWN_W        = 3;
  localparam logic [DOWN_W-1:0] DOWN_RESET = 3'd2;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       last;
  } out_t;

  // sample store write request from the front
  typedef struct packed {
    logic             we;
    logic             bank;
    logic [IDX_W-1:0] idx;
    in_t              data;
  } wr_req_t;

  // bank handed back to the front once all its taps are read
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // sinc(i/3) in q2.15, zero at nonzero multiples of three
  function automatic logic signed [COEF_W-1:0] bsr_coef(input logic [COEF_IW-1:0] idx);
    logic signed [COEF_W-1:0] c;
    unique case (idx)
      6'd0:    c = 17'sd32768;
      6'd1:    c = 17'sd27099;
      6'd2:    c = 17'sd13549;
      6'd4:    c = -17'sd6775;
      6'd5:    c = -17'sd5420;
      6'd7:    c = 17'sd3871;
      6'd8:    c = 17'sd3387;
      6'd10:   c = -17'sd2710;
      6'd11:   c = -17'sd2464;
      6'd13:   c = 17'sd2085;
      6'd14:   c = 17'sd1936;
      6'd16:   c = -17'sd1694;
      6'd17:   c = -17'sd1594;
      6'd19:   c = 17'sd1426;
      6'd20:   c = 17'sd1355;
      6'd22:   c = -17'sd1232;
      6'd23:   c = -17'sd1178;
      6'd25:   c = 17'sd1084;
      6'd26:   c = 17'sd1042;
      6'd28:   c = -17'sd968;
      6'd29:   c = -17'sd934;
      6'd31:   c = 17'sd874;
      6'd32:   c = 17'sd847;
      6'd34:   c = -17'sd797;
      6'd35:   c = -17'sd774;
      6'd37:   c = 17'sd732;
      6'd38:   c = 17'sd713;
      6'd40:   c = -17'sd677;
      6'd41:   c = -17'sd661;
      6'd43:   c = 17'sd630;
      6'd44:   c = 17'sd616;
      6'd46:   c = -17'sd589;
      6'd47:   c = -17'sd577;
      6'd49:   c = 17'sd553;
      6'd50:   c = 17'sd542;
      6'd52:   c = -17'sd521;
      6'd53:   c = -17'sd511;
      6'd55:   c = 17'sd493;
      6'd56:   c = 17'sd484;
      6'd58:   c = -17'sd467;
      6'd59:   c = -17'sd459;
      6'd61:   c = 17'sd444;
      6'd62:   c = 17'sd437;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/bsr_front.sv -----
// front end: takes sample requests, fills the banks and posts full blocks
module bsr_front #(
  parameter int unsigned BLOCK_LEN = bsr_pkg::BLOCK_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bsr_pkg::in_t      in_i,
  output logic              busy_o,
  output bsr_pkg::wr_req_t  wr_o,
  output logic              push_o,
  output logic              push_bank_o,
  input  bsr_pkg::rel_t     rel_i
);
  import bsr_pkg::*;

  localparam int unsigned JW = $clog2(BLOCK_LEN);

  logic [JW-1:0] fill_q, fill_d;
  logic          wr_bank_q, wr_bank_d;
  logic [1:0]    bank_busy_q, bank_busy_d;
  logic          accept;
  logic          blk_end;

  assign accept  = start_i && !bank_busy_q[wr_bank_q];
  assign blk_end = (fill_q == JW'(BLOCK_LEN - 1));
  assign busy_o  = bank_busy_q[wr_bank_q];

  always_comb begin
    fill_d      = fill_q;
    wr_bank_d   = wr_bank_q;
    bank_busy_d = bank_busy_q;
    if (rel_i.valid) begin
      bank_busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (blk_end) begin
        fill_d                 = '0;
        wr_bank_d              = !wr_bank_q;
        bank_busy_d[wr_bank_q] = 1'b1;
      end else begin
        fill_d = fill_q + JW'(1);
      end
    end
  end

  always_comb begin
    wr_o.we     = accept;
    wr_o.bank   = wr_bank_q;
    wr_o.idx    = IDX_W'(fill_q);
    wr_o.data   = in_i;
    push_o      = accept && blk_end;
    push_bank_o = wr_bank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      wr_bank_q   <= 1'b0;
      bank_busy_q <= '0;
    end else begin
      fill_q      <= fill_d;
      wr_bank_q   <= wr_bank_d;
      bank_busy_q <= bank_busy_d;
    end
  end

endmodule

// ----- hdl/bsr_queue.sv -----
// short queue of full-block bank ids between front and back
module bsr_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic push_bank_i,
  input  logic pop_i,
  output logic empty_o,
  output logic bank_o
);
  import bsr_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  logic          entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign bank_o  = entry_q[rp_q];
  assign do_push = push_i && (cnt_q != (PW+1)'(QUEUE_DEPTH));
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wp_q] <= push_bank_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- hdl/bsr_back.sv -----
// back end: sample store, tap sequencer and the two-channel mac pipeline
module bsr_back #(
  parameter int unsigned BLOCK_LEN = bsr_pkg::BLOCK_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bsr_pkg::wr_req_t             wr_i,
  input  logic [bsr_pkg::DOWN_W-1:0]   down_i,
  input  logic                         tok_valid_i,
  input  logic                         tok_bank_i,
  output logic                         pop_o,
  output bsr_pkg::rel_t                rel_o,
  output logic                         valid_o,
  output bsr_pkg::out_t                res_o
);
  import bsr_pkg::*;

  localparam int unsigned UP_LEN = BLOCK_LEN * UP_FACTOR - UP_FACTOR + 1;
  localparam int unsigned KW     = $clog2(UP_LEN + 8);
  localparam int unsigned JW     = $clog2(BLOCK_LEN);
  localparam int unsigned DEPTH  = 2 * BLOCK_LEN;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned PROD_W = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned SH_W   = ACC_W - 15;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef struct packed {
    logic v;
    logic first;
    logic last;
    logic blast;
  } tap_t;

  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [SH_W-1:0]  sh;
    logic signed [SAMPLE_W-1:0] y;
    r  = a + $signed(ACC_W'(16384));
    sh = $signed(r[ACC_W-1:15]);
    if (sh > $signed(SH_W'(32767))) begin
      y = 16'sh7fff;
    end else if (sh < -$signed(SH_W'(32768))) begin
      y = -16'sh8000;
    end else begin
      y = sh[SAMPLE_W-1:0];
    end
    return y;
  endfunction

  in_t sample_mem [DEPTH];
  in_t rd_q;

  state_e        state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic [JW-1:0] j_q, j_d;
  logic          bank_q, bank_d;

  logic [KW-1:0] d_eff, k_next, uj, ci_full;
  logic          tap_last, blk_last, issue;
  logic [AW-1:0] waddr, raddr;

  tap_t                        s1_q, s2_q;
  logic signed [COEF_W-1:0]    coef_q;
  logic signed [PROD_W-1:0]    prod_l_q, prod_r_q;
  logic signed [ACC_W-1:0]     acc_l_q, acc_r_q;
  logic                        fin_q, fin_last_q;
  logic                        valid_q;
  out_t                        res_q;

  assign d_eff    = (down_i == '0) ? KW'(1) : KW'(down_i);
  assign k_next   = k_q + d_eff;
  assign blk_last = (k_next >= KW'(UP_LEN));
  assign tap_last = (j_q == JW'(BLOCK_LEN - 1));
  assign issue    = (state_q == ST_RUN);
  assign uj       = KW'(j_q) * KW'(UP_FACTOR);
  assign ci_full  = (k_q >= uj) ? (k_q - uj) : (uj - k_q);

  assign waddr = wr_i.bank ? (AW'(BLOCK_LEN) + AW'(wr_i.idx)) : AW'(wr_i.idx);
  assign raddr = bank_q ? (AW'(BLOCK_LEN) + AW'(j_q)) : AW'(j_q);

  // tap sequencer: one coefficient per cycle while in ST_RUN, the tap walks of a block back to back
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    bank_d  = bank_q;
    pop_o   = 1'b0;
    rel_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (tok_valid_i) begin
          pop_o   = 1'b1;
          bank_d  = tok_bank_i;
          k_d     = '0;
          j_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tap_last) begin
          j_d = '0;
          k_d = k_next;
          if (blk_last) begin
            state_d    = ST_IDLE;
            rel_o.valid = 1'b1;
            rel_o.bank  = bank_q;
          end
        end else begin
          j_d = j_q + JW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      sample_mem[waddr] <= wr_i.data;
    end
    rd_q <= sample_mem[raddr];
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    coef_q   <= bsr_coef(COEF_IW'(ci_full));
    prod_l_q <= rd_q.left_sample * coef_q;
    prod_r_q <= rd_q.right_sample * coef_q;
    if (s2_q.v) begin
      acc_l_q <= (s2_q.first ? '0 : acc_l_q) + ACC_W'(prod_l_q);
      acc_r_q <= (s2_q.first ? '0 : acc_r_q) + ACC_W'(prod_r_q);
    end
    if (fin_q) begin
      res_q.left_out  <= round_sat(acc_l_q);
      res_q.right_out <= round_sat(acc_r_q);
      res_q.last      <= fin_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= '0;
      j_q        <= '0;
      bank_q     <= 1'b0;
      s1_q       <= '0;
      s2_q       <= '0;
      fin_q      <= 1'b0;
      fin_last_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      j_q        <= j_d;
      bank_q     <= bank_d;
      s1_q.v     <= issue;
      s1_q.first <= (j_q == '0);
      s1_q.last  <= tap_last;
      s1_q.blast <= blk_last;
      s2_q       <= s1_q;
      fin_q      <= s2_q.v && s2_q.last;
      fin_last_q <= s2_q.blast;
      valid_q    <= fin_q;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- hdl/block_sinc_rational_resampler.sv -----
// top level of the stereo block sinc resampler
//
//  channel   signals                     direction  handshake
//  sample    start, busy, in_i           in         taken when start && !busy
//  result    valid_o, res_o              out        one-cycle strobe, no stall
//  config    cfg_we_i, cfg_wdata_i       in         down factor, written on cfg_we_i
//
// a full block yields one result per walk over its stored samples, all from a
// single shared mac pair
// two sample banks: busy rises only while both banks still hold unfinished blocks
// reset clears control state; the sample store is not cleared
module block_sinc_rational_resampler #(
  parameter int unsigned BLOCK_LEN = bsr_pkg::BLOCK_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  bsr_pkg::in_t                in_i,
  input  logic                        cfg_we_i,
  input  logic [bsr_pkg::DOWN_W-1:0]  cfg_wdata_i,
  output logic                        valid_o,
  output bsr_pkg::out_t               res_o
);
  import bsr_pkg::*;

  logic [DOWN_W-1:0] down_q;
  wr_req_t           wr_req;
  rel_t              rel;
  logic              push, push_bank, pop, q_empty, q_bank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q <= DOWN_RESET;
    end else if (cfg_we_i) begin
      down_q <= cfg_wdata_i;
    end
  end

  bsr_front #(.BLOCK_LEN(BLOCK_LEN)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .in_i        (in_i),
    .busy_o      (busy),
    .wr_o        (wr_req),
    .push_o      (push),
    .push_bank_o (push_bank),
    .rel_i       (rel)
  );

  bsr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_bank_i (push_bank),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .bank_o      (q_bank)
  );

  bsr_back #(.BLOCK_LEN(BLOCK_LEN)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr_req),
    .down_i      (down_q),
    .tok_valid_i (!q_empty),
    .tok_bank_i  (q_bank),
    .pop_o       (pop),
    .rel_o       (rel),
    .valid_o     (valid_o),
    .res_o       (res_o)
  );

endmodule

// ----- hdl/bsr_checker.sv -----
// port-level checks for the block resampler, bound to the top level
module bsr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        valid_o,
  input bsr_pkg::out_t               res_o
);
  import bsr_pkg::*;

  // results are at least one tap walk apart; checked here as no two strobes in a row
  a_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("back-to-back result strobes");

  // busy only rises right after a request closed a block
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted request");

  // nothing comes out in the first cycle after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !valid_o)
    else $error("result strobe right after reset");

  // a strobed result carries fully known data
  a_res_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !$isunknown(res_o))
    else $error("unknown bits on a strobed result");

endmodule

bind block_sinc_rational_resampler bsr_checker u_bsr_checker (.*);

// ----- dv/tb_block_sinc_rational_resampler.sv -----
`timescale 1ns / 1ps
// testbench for the block sinc resampler, checked against a bit-true predictor
module tb_block_sinc_rational_resampler;
  import bsr_pkg::*;

  localparam int unsigned BLK          = BLOCK_LEN_DEF;
  localparam int unsigned UP_LEN       = BLK * UP_FACTOR - UP_FACTOR + 1;
  localparam int unsigned SETTLE       = 4 * BLK + 16;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam longint unsigned CYCLE_LIMIT = 800000;
  localparam longint unsigned PI_Q4_28    = 64'd843314856;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_EXTREME,
    FILL_SMALL,
    FILL_IMPULSE,
    FILL_FLAT
  } fill_e;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  in_t               in_i;
  logic              cfg_we_i;
  logic [DOWN_W-1:0] cfg_wdata_i;
  logic              valid_o;
  out_t              res_o;

  // predictor state
  logic signed [SAMPLE_W-1:0] left_hist [BLK];
  logic signed [SAMPLE_W-1:0] right_hist[BLK];
  int unsigned                fill_cnt = 0;
  logic [DOWN_W-1:0]          down_cur = DOWN_RESET;
  out_t                       expected_q[$];

  int unsigned     mismatch_cnt = 0;
  longint unsigned cycle_cnt    = 0;
  int unsigned     burst_left   = 0;
  bit              steady       = 1'b0;

  block_sinc_rational_resampler #(
    .BLOCK_LEN(BLK)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_o    (valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // sinc(i/up) in q2.15, built from the sin(pi*q/6) table
  function automatic longint sinc_tap(input int unsigned i);
    int unsigned     q;
    longint unsigned s, num, den, mag;
    bit              neg;
    if (i == 0) return 32768;
    q   = (i * (6 / UP_FACTOR)) % 12;
    neg = q > 6;
    case (neg ? q - 6 : q)
      1, 5:    s = 64'd536870912;
      2, 4:    s = 64'd929887697;
      3:       s = 64'd1073741824;
      default: s = 64'd0;
    endcase
    num = (longint'(UP_FACTOR) * s) << 13;
    den = PI_Q4_28 * i;
    mag = (2 * num + den) / (2 * den);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] q15_sat(input longint acc);
    longint v;
    v = (acc + 16384) >>> 15;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  // interpolate the stored block by UP_FACTOR, then keep every d-th point
  function automatic void resample_block();
    int unsigned d, k, j, tap_idx;
    longint      acc_l, acc_r, tap;
    out_t        r;
    d = (down_cur == '0) ? 1 : 32'(down_cur);
    for (k = 0; k < UP_LEN; k += d) begin
      acc_l = 0;
      acc_r = 0;
      for (j = 0; j < BLK; j++) begin
        tap_idx = (k >= UP_FACTOR * j) ? k - UP_FACTOR * j : UP_FACTOR * j - k;
        tap     = sinc_tap(tap_idx);
        acc_l += longint'(left_hist[j]) * tap;
        acc_r += longint'(right_hist[j]) * tap;
      end
      r.left_out  = q15_sat(acc_l);
      r.right_out = q15_sat(acc_r);
      r.last      = (k + d >= UP_LEN);
      expected_q.push_back(r);
    end
  endfunction

  task automatic send_item(input in_t s);
    int unsigned gap;
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= s;
    do @(posedge clk_i); while (busy);
    if (fill_cnt >= BLK) fill_cnt = 0;
    left_hist[fill_cnt]  = s.left_sample;
    right_hist[fill_cnt] = s.right_sample;
    fill_cnt++;
    if (fill_cnt == BLK) begin
      fill_cnt = 0;
      resample_block();
    end
    // bursts of requests with random gaps, long ones now and then
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      if (steady) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(20, 70);
      else gap = $urandom_range(0, 5);
      if (gap != 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic send_block(input fill_e mode, input int unsigned n);
    int unsigned peak;
    in_t         level, s;
    int          v;
    peak  = $urandom_range(0, BLK - 1);
    level = in_t'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        FILL_EXTREME: begin
          s.left_sample  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          s.right_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end
        FILL_SMALL: begin
          v = int'($urandom_range(0, 512)) - 256;
          s.left_sample = v[SAMPLE_W-1:0];
          v = int'($urandom_range(0, 512)) - 256;
          s.right_sample = v[SAMPLE_W-1:0];
        end
        FILL_IMPULSE: s = (i == peak) ? level : '0;
        FILL_FLAT:    s = level;
        default:      s = in_t'($urandom);
      endcase
      send_item(s);
    end
  endtask

  function automatic fill_e pick_fill();
    if ($urandom_range(0, 7) < 3) return FILL_RANDOM;
    return fill_e'($urandom_range(0, 4));
  endfunction

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    // a partly filled block may still be in flight without any result due
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_down(input logic [DOWN_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    down_cur = v;
  endtask

  // full-scale block at the reset down factor, drives the output into saturation
  task automatic test_extreme_block();
    in_t s;
    steady = 1'b1;
    for (int unsigned j = 0; j < BLK; j++) begin
      if (j < BLK / 2) begin
        s.left_sample  = j[0] ? 16'sh8000 : 16'sh7fff;
        s.right_sample = 16'sh7fff;
      end else begin
        s.left_sample  = (j == BLK - 1) ? 16'sh0000 : 16'sh7fff;
        s.right_sample = j[0] ? 16'sh8000 : 16'sh0001;
      end
      send_item(s);
    end
    wait_drained();
  endtask

  // zero acts as one, values above four give short blocks
  task automatic test_down_factor_range();
    logic [DOWN_W-1:0] vals[7] = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd5, 3'd6, 3'd3};
    foreach (vals[i]) begin
      write_down(vals[i]);
      steady = (i % 2 == 0);
      send_block(pick_fill(), BLK);
      wait_drained();
    end
  endtask

  // a block that straddles a down factor change takes the new value
  task automatic test_split_block();
    steady = 1'b0;
    write_down(3'd2);
    send_block(FILL_RANDOM, 7);
    wait_drained();
    write_down(3'd4);
    send_block(FILL_EXTREME, BLK - 7);
    send_block(FILL_IMPULSE, BLK);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned sent, nblk;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) write_down(DOWN_W'($urandom_range(1, 4)));
      else write_down(DOWN_W'($urandom_range(0, 7)));
      steady = ($urandom_range(0, 3) == 0);
      nblk   = $urandom_range(1, 3);
      repeat (nblk) send_block(pick_fill(), BLK);
      sent += nblk * BLK;
      wait_drained();
    end
  endtask

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: left %0d right %0d last %0d",
                   res_o.left_out, res_o.right_out, res_o.last);
      end else begin
        want = expected_q.pop_front();
        if (res_o.left_out !== want.left_out || res_o.right_out !== want.right_out ||
            res_o.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: expected left %0d right %0d last %0d,",
                     want.left_out, want.right_out, want.last,
                     " got left %0d right %0d last %0d",
                     res_o.left_out, res_o.right_out, res_o.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_block_sinc_rational_resampler: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extreme_block();
    test_down_factor_range();
    test_split_block();
    test_random_traffic();

    if (mismatch_cnt == 0) begin
      $display("tb_block_sinc_rational_resampler: PASS");
    end else begin
      $display("tb_block_sinc_rational_resampler: FAIL");
    end
    $finish;
  end

endmodule
